// ----- rtl/cvct_pkg.sv -----
// cvct_pkg: shared types and constants of the convex volume cull test
// plane register layout, shape transaction layout and arithmetic widths
// no dependencies
`default_nettype none

package cvct_pkg;

    // field widths
    localparam int NORM_BITS = 13;   // plane normal component, signed q1.11
    localparam int OFFS_BITS = 25;   // plane offset, signed q16.8
    localparam int NORM_FRAC = 11;   // fraction bits of a normal component
    localparam int POS_BITS  = 24;   // centre coordinate, signed q15.8
    localparam int LEN_BITS  = 23;   // radius and half extents, unsigned q15.8

    // arithmetic widths, all terms in the common q.19 scale
    localparam int PROD_BITS     = NORM_BITS + POS_BITS;       // normal times centre
    localparam int MAG_PROD_BITS = NORM_BITS + LEN_BITS;       // |normal| times extent
    localparam int BIAS_BITS     = OFFS_BITS + 1;              // offset plus radius
    localparam int SUM_BITS      = PROD_BITS + 4;              // seven terms, exact

    // configuration port
    localparam int PLANE_REGS    = 6;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int COUNT_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_0     = 3'd1;

    // shape kinds
    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    // plane register, msb first: offset, nz, ny, nx
    typedef struct packed {
        logic signed [OFFS_BITS-1:0] w;
        logic signed [NORM_BITS-1:0] nz;
        logic signed [NORM_BITS-1:0] ny;
        logic signed [NORM_BITS-1:0] nx;
    } t_plane;

    // one shape under test
    typedef struct packed {
        logic                       kind;
        logic signed [POS_BITS-1:0] center_x;
        logic signed [POS_BITS-1:0] center_y;
        logic signed [POS_BITS-1:0] center_z;
        logic        [LEN_BITS-1:0] radius;
        logic        [LEN_BITS-1:0] extent_x;
        logic        [LEN_BITS-1:0] extent_y;
        logic        [LEN_BITS-1:0] extent_z;
    } t_shape;

    // magnitude of a normal component; the most negative code maps to 4096
    function automatic logic [NORM_BITS-1:0] abs_norm(input logic signed [NORM_BITS-1:0] v);
        logic [NORM_BITS-1:0] neg;
        neg = NORM_BITS'(~v) + NORM_BITS'(1);
        return v[NORM_BITS-1] ? neg : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cvct_cfg.sv -----
// cvct_cfg: plane count and plane registers of the convex volume cull test
// decodes the write port and gives one enable bit per plane lane
// depends on cvct_pkg
`default_nettype none

module cvct_cfg #(
    parameter int NUM_LANES = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cvct_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [cvct_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output cvct_pkg::t_plane                      o_planes [NUM_LANES],
    output logic [NUM_LANES-1:0]                  o_lane_on
);
    import cvct_pkg::*;

    logic [COUNT_BITS-1:0] r_plane_count;
    t_plane                r_planes [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= '0;
        end else if (i_cfg_we && i_cfg_idx == REG_PLANE_COUNT) begin
            r_plane_count <= i_cfg_data[COUNT_BITS-1:0];
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_planes[g] <= '0;
            end else if (i_cfg_we && i_cfg_idx == CFG_IDX_BITS'(REG_PLANE_0 + g)) begin
                r_planes[g] <= i_cfg_data;
            end
        end

        // a count above the lane total saturates by itself
        assign o_lane_on[g] = (r_plane_count > COUNT_BITS'(g));
        assign o_planes[g]  = r_planes[g];
    end

endmodule

`default_nettype wire

// ----- rtl/cvct_lane.sv -----
// cvct_lane: one plane of the convex volume cull test
// registered products, then a seven term sum whose sign says culled
// depends on cvct_pkg
`default_nettype none

module cvct_lane (
    input  logic             i_clk,
    input  logic             i_en,
    input  cvct_pkg::t_shape i_shape,
    input  cvct_pkg::t_plane i_plane,
    output logic             o_culled
);
    import cvct_pkg::*;

    logic                        is_box;
    logic [NORM_BITS-1:0]        mag_x, mag_y, mag_z;
    logic [LEN_BITS-1:0]         ext_x, ext_y, ext_z;
    logic [LEN_BITS-1:0]         rad_sel;
    logic signed [BIAS_BITS-1:0] n_bias_raw;

    logic signed [PROD_BITS-1:0] n_dx, n_dy, n_dz;
    logic [MAG_PROD_BITS-1:0]    n_ax, n_ay, n_az;

    logic signed [PROD_BITS-1:0] r_dx, r_dy, r_dz;
    logic [MAG_PROD_BITS-1:0]    r_ax, r_ay, r_az;
    logic [PROD_BITS-1:0]        r_bias;

    logic [SUM_BITS-1:0]         sum;

    assign is_box = (i_shape.kind == KIND_BOX);
    assign mag_x  = abs_norm(i_plane.nx);
    assign mag_y  = abs_norm(i_plane.ny);
    assign mag_z  = abs_norm(i_plane.nz);

    // unused shape fields drop out
    assign ext_x   = is_box ? i_shape.extent_x : '0;
    assign ext_y   = is_box ? i_shape.extent_y : '0;
    assign ext_z   = is_box ? i_shape.extent_z : '0;
    assign rad_sel = is_box ? '0 : i_shape.radius;

    assign n_dx = PROD_BITS'(i_plane.nx) * PROD_BITS'(i_shape.center_x);
    assign n_dy = PROD_BITS'(i_plane.ny) * PROD_BITS'(i_shape.center_y);
    assign n_dz = PROD_BITS'(i_plane.nz) * PROD_BITS'(i_shape.center_z);

    assign n_ax = MAG_PROD_BITS'(mag_x) * MAG_PROD_BITS'(ext_x);
    assign n_ay = MAG_PROD_BITS'(mag_y) * MAG_PROD_BITS'(ext_y);
    assign n_az = MAG_PROD_BITS'(mag_z) * MAG_PROD_BITS'(ext_z);

    // offset plus sphere radius, both q.8
    assign n_bias_raw = {i_plane.w[OFFS_BITS-1], i_plane.w}
                      + $signed({{(BIAS_BITS-LEN_BITS){1'b0}}, rad_sel});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_dz   <= n_dz;
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_az   <= n_az;
            r_bias <= {n_bias_raw, {NORM_FRAC{1'b0}}};
        end
    end

    // dist + bound, exact in q.19
    assign sum = {{(SUM_BITS-PROD_BITS){r_dx[PROD_BITS-1]}}, r_dx}
               + {{(SUM_BITS-PROD_BITS){r_dy[PROD_BITS-1]}}, r_dy}
               + {{(SUM_BITS-PROD_BITS){r_dz[PROD_BITS-1]}}, r_dz}
               + {{(SUM_BITS-MAG_PROD_BITS){1'b0}}, r_ax}
               + {{(SUM_BITS-MAG_PROD_BITS){1'b0}}, r_ay}
               + {{(SUM_BITS-MAG_PROD_BITS){1'b0}}, r_az}
               + {{(SUM_BITS-PROD_BITS){r_bias[PROD_BITS-1]}}, r_bias};

    assign o_culled = sum[SUM_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/convex_volume_cull_test.sv -----
// convex_volume_cull_test: sphere / box visibility test against up to six planes
// top level: input register, per-plane product lanes, result register
// depends on cvct_pkg, cvct_cfg, cvct_lane
`default_nettype none

//  channel   direction  handshake                    payload
//  in        to block   i_in_valid / o_in_stall      i_kind, i_center_*, i_radius, i_extent_*
//  out       from block o_out_valid / i_out_stall    o_visible
//  cfg       to block   i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  one transaction per cycle sustained while the sink does not stall; each result
//  passes the input register, the product register in every lane and the result register
//  reset is synchronous and clears the pipeline valids and all config registers
//  a stall on a held output result freezes all three stages together, so the input is
//  stalled in that same cycle; bubbles never hold up a transaction

module convex_volume_cull_test #(
    parameter int MAX_PLANES = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [cvct_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [cvct_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [cvct_pkg::POS_BITS-1:0] i_center_x,
    input  logic signed [cvct_pkg::POS_BITS-1:0] i_center_y,
    input  logic signed [cvct_pkg::POS_BITS-1:0] i_center_z,
    input  logic [cvct_pkg::LEN_BITS-1:0]       i_radius,
    input  logic [cvct_pkg::LEN_BITS-1:0]       i_extent_x,
    input  logic [cvct_pkg::LEN_BITS-1:0]       i_extent_y,
    input  logic [cvct_pkg::LEN_BITS-1:0]       i_extent_z,

    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_visible
);
    import cvct_pkg::*;

    // lanes beyond the plane registers that exist would never be active
    localparam int NUM_LANES = (MAX_PLANES < PLANE_REGS) ? MAX_PLANES : PLANE_REGS;

    t_plane                 planes [NUM_LANES];
    logic [NUM_LANES-1:0]   lane_on;
    logic [NUM_LANES-1:0]   lane_culled;

    logic                   pipe_en;
    t_shape                 r_shape;
    logic                   r_s1_valid;
    logic                   r_s2_valid;
    logic                   r_out_valid;
    logic                   r_visible;

    cvct_cfg #(
        .NUM_LANES (NUM_LANES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (planes),
        .o_lane_on  (lane_on)
    );

    // whole pipeline moves unless a finished result is held by the sink
    assign pipe_en    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !pipe_en;

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_shape.kind     <= i_kind;
            r_shape.center_x <= i_center_x;
            r_shape.center_y <= i_center_y;
            r_shape.center_z <= i_center_z;
            r_shape.radius   <= i_radius;
            r_shape.extent_x <= i_extent_x;
            r_shape.extent_y <= i_extent_y;
            r_shape.extent_z <= i_extent_z;
        end
    end

    // stage 2: one lane per plane, products registered inside
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        cvct_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (pipe_en),
            .i_shape  (r_shape),
            .i_plane  (planes[g]),
            .o_culled (lane_culled[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // stage 3: visible unless an active plane has the shape fully outside
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_visible <= ~|(lane_culled & lane_on);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

endmodule

`default_nettype wire
